// File: hdl/stuffed_parameter_frame_builder_macros.svh
// Assertion helpers shared by the frame builder RTL.
`ifndef STUFFED_PARAMETER_FRAME_BUILDER_MACROS_SVH
`define STUFFED_PARAMETER_FRAME_BUILDER_MACROS_SVH

// Condition must hold at every rising clock edge out of reset.
`define SFB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/sfb_pkg.sv
`default_nettype none

package sfb_pkg;

	// Default frame memory depth in bytes
	localparam int BUFFER_DEPTH_DEF = 1024;

	// Fixed field widths
	localparam int LEN_W     = 11;
	localparam int RA_W      = 10;
	localparam int K_W       = 4;

	// Frame layout: length bytes start at 2, first record at 4
	localparam int LEN_POS   = 2;
	localparam int FIRST_REC = 4;
	// Last index of the fixed part of a record (ctrl, start, type, idx hi, idx lo)
	localparam int REC_FIXED_LAST = 4;
	// Last trailer byte index (ctrl, end code, checksum, pad)
	localparam int TRL_LAST  = 3;

	localparam logic [7:0] TRAILER_PAD = 8'h00;

	// Supported type codes
	localparam logic [7:0] TYPE_U8  = 8'h11;
	localparam logic [7:0] TYPE_S8  = 8'h12;
	localparam logic [7:0] TYPE_U16 = 8'h21;
	localparam logic [7:0] TYPE_S16 = 8'h22;
	localparam logic [7:0] TYPE_U32 = 8'h41;
	localparam logic [7:0] TYPE_S32 = 8'h42;
	localparam logic [7:0] TYPE_F32 = 8'h43;
	localparam logic [7:0] TYPE_U64 = 8'h81;
	localparam logic [7:0] TYPE_S64 = 8'h82;
	localparam logic [7:0] TYPE_F64 = 8'h83;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_ADD   = 2'd1,
		OP_END   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CONTROL     = 2'd0,
		REG_FRAME_START = 2'd1,
		REG_FRAME_END   = 2'd2,
		REG_PARAM_START = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [7:0]      type_code;
		logic [15:0]     param_index;
		logic [63:0]     param_data;
		logic [RA_W-1:0] read_address;
	} in_t;

	typedef struct packed {
		logic [7:0]       read_byte;
		logic [LEN_W-1:0] total_length;
		logic [LEN_W-1:0] length_field;
		logic [1:0]       status;
	} out_t;

	// Data byte count per type code, zero for unsupported codes
	function automatic logic [K_W-1:0] data_bytes(input logic [7:0] code);
		case (code) inside
			TYPE_U8, TYPE_S8:             return K_W'(1);
			TYPE_U16, TYPE_S16:           return K_W'(2);
			TYPE_U32, TYPE_S32, TYPE_F32: return K_W'(4);
			TYPE_U64, TYPE_S64, TYPE_F64: return K_W'(8);
			default:                      return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: hdl/stuffed_parameter_frame_builder.sv
// Channel | Signals                                 | Transfer when
// --------+-----------------------------------------+----------------------------
// in      | in_valid, in_ready, in_data (in_t)      | in_valid & in_ready
// out     | out_valid, out_ready, out_data (out_t)  | out_valid & out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One item at a time; the byte-wide frame RAM write port sets the pace.
// Add writes the stuffed record bytes; bad or late adds write nothing. Begin writes two bytes.
// End shifts the records up when a length byte needs escaping and drains the last shift write,
//   then writes the length header, reads every frame byte for the checksum and writes the trailer.
// Reset clears control state only; frame RAM is undefined until written.
// A result held by out_ready stalls the next item in its last cycle, not at its transfer.
`default_nettype none

`include "stuffed_parameter_frame_builder_macros.svh"

module stuffed_parameter_frame_builder #(
	parameter int BUFFER_DEPTH = sfb_pkg::BUFFER_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sfb_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sfb_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	import sfb_pkg::*;

	localparam int AW  = $clog2(BUFFER_DEPTH);
	localparam int PW  = $clog2(BUFFER_DEPTH + 1);
	localparam int PW1 = PW + 1;
	localparam int CW  = (PW > RA_W) ? PW : RA_W;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_BEGIN  = 11'b000_0000_0010,
		S_ADD    = 11'b000_0000_0100,
		S_SHIFT  = 11'b000_0000_1000,
		S_DRAIN  = 11'b000_0001_0000,
		S_HDR    = 11'b000_0010_0000,
		S_SUM    = 11'b000_0100_0000,
		S_TRL    = 11'b000_1000_0000,
		S_RD     = 11'b001_0000_0000,
		S_RD_CAP = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	state_t         state_q;
	in_t            item_q;
	out_t           out_q;
	out_t           out_next;
	logic           out_valid_q;

	// Configuration registers
	logic [7:0]     cc_q;
	logic [7:0]     fsc_q;
	logic [7:0]     fec_q;
	logic [7:0]     psc_q;

	// Frame state
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  len_q;
	logic [7:0]     xor_q;
	logic [1:0]     esc_q;
	logic           done_q;
	logic           ovf_q;
	logic           bad_q;

	// Sequencer
	logic [K_W-1:0] k_q;
	logic           dup_q;
	logic [PW-1:0]  ptr_q;
	logic           hi_esc_q;
	logic [7:0]     hdr_hi_q;
	logic [7:0]     hdr_lo_q;
	logic [7:0]     byte_q;

	// Read pipeline
	logic           shift_vld_s1;
	logic           sum_vld_s1;
	logic [AW-1:0]  wr_addr_s1;

	// RAM port
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	logic           accept;
	logic           room;
	logic           fin_load;
	logic           rd_in_range;

	// Record byte selection
	logic [K_W-1:0]     n_in;
	logic [K_W-1:0]     n_item;
	logic [K_W-1:0]     add_last;
	logic [K_W-1:0]     dsel_full;
	logic [7:0][7:0]    d_bytes;
	logic [7:0]         add_byte;
	logic               add_dup;

	// End-of-frame length math
	logic [15:0]    len16;
	logic           hi_e;
	logic           lo_e;
	logic [1:0]     esc_in;
	logic [PW1-1:0] ne_full;
	logic           ne_ovf;
	logic [PW-1:0]  ne;
	logic           need_shift;
	logic [PW-1:0]  ptr_start;
	logic [K_W-1:0] hdr_last;
	logic [7:0]     hdr_byte;
	logic [7:0]     trl_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign room      = (wp_q < PW'(BUFFER_DEPTH));
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign rd_in_range = (CW'(item_q.read_address) < CW'(BUFFER_DEPTH));

	// Record bytes: fixed part, then data bytes most significant first
	assign n_in      = data_bytes(in_data.type_code);
	assign n_item    = data_bytes(item_q.type_code);
	assign add_last  = K_W'(REC_FIXED_LAST) + n_item;
	assign dsel_full = add_last - k_q;
	assign d_bytes   = item_q.param_data;

	always_comb begin
		case (k_q)
			K_W'(0):  add_byte = cc_q;
			K_W'(1):  add_byte = psc_q;
			K_W'(2):  add_byte = item_q.type_code;
			K_W'(3):  add_byte = item_q.param_index[15:8];
			K_W'(4):  add_byte = item_q.param_index[7:0];
			default:  add_byte = d_bytes[dsel_full[2:0]];
		endcase
	end

	// Leading control char is never doubled
	assign add_dup = (k_q != '0) && (add_byte == cc_q) && !dup_q;

	// Length escapes and the new frame end
	assign len16      = 16'(wp_q);
	assign hi_e       = (len16[15:8] == cc_q);
	assign lo_e       = (len16[7:0] == cc_q);
	assign esc_in     = {1'b0, hi_e} + {1'b0, lo_e};
	assign ne_full    = {1'b0, wp_q} + PW1'(esc_in);
	assign ne_ovf     = (ne_full > PW1'(BUFFER_DEPTH));
	assign ne         = ne_ovf ? PW'(BUFFER_DEPTH) : ne_full[PW-1:0];
	assign need_shift = (esc_in != 2'd0) &&
		({1'b0, ne} >= PW1'(FIRST_REC + 1) + PW1'(esc_in));
	assign ptr_start  = ne - PW'(1) - PW'(esc_in);

	// Header bytes: hi, optional hi copy, lo, optional lo copy
	assign hdr_last = K_W'(1) + K_W'(esc_q);
	always_comb begin
		case (k_q)
			K_W'(0):  hdr_byte = hdr_hi_q;
			K_W'(1):  hdr_byte = hi_esc_q ? hdr_hi_q : hdr_lo_q;
			default:  hdr_byte = hdr_lo_q;
		endcase
	end

	always_comb begin
		case (k_q[1:0])
			2'd0:    trl_byte = cc_q;
			2'd1:    trl_byte = fec_q;
			2'd2:    trl_byte = xor_q;
			default: trl_byte = TRAILER_PAD;
		endcase
	end

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q[AW-1:0];
		ram_wdata = add_byte;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		case (state_q)
			S_BEGIN: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(k_q);
				ram_wdata = (k_q == '0) ? cc_q : fsc_q;
			end
			S_ADD: begin
				ram_we    = room;
			end
			S_SHIFT: begin
				ram_re    = 1'b1;
				ram_we    = shift_vld_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			S_DRAIN: begin
				ram_we    = shift_vld_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			S_HDR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(LEN_POS) + AW'(k_q);
				ram_wdata = hdr_byte;
			end
			S_SUM: begin
				ram_re    = 1'b1;
			end
			S_TRL: begin
				ram_we    = room;
				ram_wdata = trl_byte;
			end
			S_RD: begin
				ram_re    = rd_in_range;
				ram_raddr = AW'(item_q.read_address);
			end
			default: begin
			end
		endcase
	end

	sfb_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result for the finished item
	always_comb begin
		out_next.read_byte    = (item_q.opcode == OP_READ) ? byte_q : 8'h00;
		out_next.total_length = done_q ? LEN_W'(wp_q) : '0;
		out_next.length_field = done_q ? LEN_W'(len_q) : '0;
		if (bad_q) begin
			out_next.status = ST_BAD_TYPE;
		end else if (ovf_q) begin
			out_next.status = ST_OVERFLOW;
		end else begin
			out_next.status = ST_OK;
		end
	end

	// Control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			cc_q         <= '0;
			fsc_q        <= '0;
			fec_q        <= '0;
			psc_q        <= '0;
			wp_q         <= PW'(FIRST_REC);
			len_q        <= '0;
			xor_q        <= '0;
			esc_q        <= '0;
			done_q       <= 1'b0;
			ovf_q        <= 1'b0;
			bad_q        <= 1'b0;
			k_q          <= '0;
			dup_q        <= 1'b0;
			ptr_q        <= '0;
			hi_esc_q     <= 1'b0;
			shift_vld_s1 <= 1'b0;
			sum_vld_s1   <= 1'b0;
		end else begin
			shift_vld_s1 <= (state_q == S_SHIFT);
			sum_vld_s1   <= (state_q == S_SUM);

			// Checksum accumulates in the cycle after each read
			if (sum_vld_s1) begin
				xor_q <= xor_q ^ ram_rdata;
			end

			if (cfg_valid) begin
				case (cfg_index)
					REG_CONTROL:     cc_q  <= cfg_data;
					REG_FRAME_START: fsc_q <= cfg_data;
					REG_FRAME_END:   fec_q <= cfg_data;
					REG_PARAM_START: psc_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// Result register: loaded from the last cycle, cleared on transfer
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bad_q <= 1'b0;
						k_q   <= '0;
						dup_q <= 1'b0;
						case (in_data.opcode)
							OP_BEGIN: begin
								wp_q    <= PW'(FIRST_REC);
								xor_q   <= '0;
								esc_q   <= '0;
								done_q  <= 1'b0;
								ovf_q   <= 1'b0;
								len_q   <= '0;
								state_q <= S_BEGIN;
							end
							OP_ADD: begin
								if (done_q) begin
									state_q <= S_FIN;
								end else if (n_in == '0) begin
									bad_q   <= 1'b1;
									state_q <= S_FIN;
								end else begin
									state_q <= S_ADD;
								end
							end
							OP_END: begin
								if (done_q) begin
									state_q <= S_FIN;
								end else begin
									len_q    <= wp_q;
									esc_q    <= esc_in;
									hi_esc_q <= hi_e;
									xor_q    <= '0;
									wp_q     <= ne;
									done_q   <= 1'b1;
									if (ne_ovf) begin
										ovf_q <= 1'b1;
									end
									ptr_q   <= ptr_start;
									state_q <= need_shift ? S_SHIFT : S_HDR;
								end
							end
							default: begin
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_BEGIN: begin
					if (k_q == K_W'(1)) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				S_ADD: begin
					if (room) begin
						wp_q <= wp_q + PW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (add_dup) begin
						dup_q <= 1'b1;
					end else begin
						dup_q <= 1'b0;
						if (k_q == add_last) begin
							state_q <= S_FIN;
						end else begin
							k_q <= k_q + K_W'(1);
						end
					end
				end
				// Move record bytes up by the escape count, top first
				S_SHIFT: begin
					if (ptr_q == PW'(FIRST_REC)) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q - PW'(1);
					end
				end
				S_DRAIN: begin
					k_q     <= '0;
					state_q <= S_HDR;
				end
				S_HDR: begin
					if (k_q == hdr_last) begin
						ptr_q   <= '0;
						state_q <= S_SUM;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				S_SUM: begin
					if (ptr_q == wp_q - PW'(1)) begin
						k_q     <= '0;
						state_q <= S_TRL;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_TRL: begin
					if (room) begin
						wp_q <= wp_q + PW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (k_q == K_W'(TRL_LAST)) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				S_RD: begin
					state_q <= S_RD_CAP;
				end
				S_RD_CAP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			if (in_data.opcode == OP_END) begin
				hdr_hi_q <= len16[15:8];
				hdr_lo_q <= len16[7:0];
			end
		end
		wr_addr_s1 <= ptr_q[AW-1:0] + AW'(esc_q);
		if (state_q == S_RD_CAP) begin
			byte_q <= rd_in_range ? ram_rdata : 8'h00;
		end
		if (fin_load) begin
			out_q <= out_next;
		end
	end

	// Checks
	`SFB_ASSERT_IMPLY(a_wr_in_range, clk, arst_n, ram_we, (PW'(ram_waddr) < PW'(BUFFER_DEPTH)), "frame RAM write beyond depth")
	`SFB_ASSERT_ALWAYS(a_wp_bound, clk, arst_n, (wp_q <= PW'(BUFFER_DEPTH)), "write position beyond depth")
	`SFB_ASSERT_IMPLY(a_shift_esc, clk, arst_n, (state_q == S_SHIFT), (esc_q != 2'd0), "shift without length escape")
	`SFB_ASSERT_IMPLY(a_shift_owner, clk, arst_n, shift_vld_s1, (state_q == S_SHIFT || state_q == S_DRAIN), "shift write outside shift phase")

endmodule

`default_nettype wire

// File: hdl/sfb_ram.sv
`default_nettype none

module sfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: tb/sv/stuffed_parameter_frame_builder_test.sv
`timescale 1ns / 1ps

module stuffed_parameter_frame_builder_test;
	import sfb_pkg::*;

	localparam int DEPTH = BUFFER_DEPTH_DEF;
	// Worst case is an end on a full frame (shift plus checksum pass) behind a long
	// receiver hold-off; this is several times that.
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 300;
	localparam logic [7:0] SUPPORTED_CODES [10] = '{TYPE_U8, TYPE_S8, TYPE_U16, TYPE_S16,
		TYPE_U32, TYPE_S32, TYPE_F32, TYPE_U64, TYPE_S64, TYPE_F64};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	stuffed_parameter_frame_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame image as the block should hold it, plus which bytes have been written
	logic [7:0] frame_mem [DEPTH];
	bit frame_wr [DEPTH];
	int unsigned wr_pos = FIRST_REC;
	int unsigned saved_len = 0;
	bit done_q = 1'b0;
	bit ovf_q = 1'b0;
	logic [7:0] cfg_ctrl = '0;
	logic [7:0] cfg_fstart = '0;
	logic [7:0] cfg_fend = '0;
	logic [7:0] cfg_pstart = '0;

	out_t expected_results [$];
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned sink_hold_cycles = 0;
	bit steady = 1'b0;

	function automatic int unsigned data_byte_count(input logic [7:0] code);
		case (code)
			TYPE_U8, TYPE_S8: return 1;
			TYPE_U16, TYPE_S16: return 2;
			TYPE_U32, TYPE_S32, TYPE_F32: return 4;
			TYPE_U64, TYPE_S64, TYPE_F64: return 8;
			default: return 0;
		endcase
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (wr_pos < DEPTH) begin
			frame_mem[wr_pos] = b;
			frame_wr[wr_pos] = 1'b1;
			wr_pos++;
		end else begin
			ovf_q = 1'b1;
		end
	endfunction

	// Record bytes other than the leading control char go in twice when they match it
	function automatic void store_stuffed(input logic [7:0] b);
		store_byte(b);
		if (b == cfg_ctrl)
			store_byte(b);
	endfunction

	// Length into the header (escaped bytes push the records up), then the trailer
	function automatic void close_frame();
		int unsigned flen, esc, new_end, p;
		logic [7:0] hi, lo, csum;
		flen = wr_pos;
		hi = 8'(flen >> 8);
		lo = 8'(flen);
		esc = int'(hi == cfg_ctrl) + int'(lo == cfg_ctrl);
		new_end = flen + esc;
		if (new_end > DEPTH) begin
			ovf_q = 1'b1;
			new_end = DEPTH;
		end
		for (int unsigned d = new_end; d > FIRST_REC + esc; d--) begin
			frame_mem[d - 1] = frame_mem[d - 1 - esc];
			frame_wr[d - 1] = 1'b1;
		end
		p = LEN_POS;
		frame_mem[p] = hi;
		p++;
		if (hi == cfg_ctrl) begin
			frame_mem[p] = hi;
			p++;
		end
		frame_mem[p] = lo;
		p++;
		if (lo == cfg_ctrl) begin
			frame_mem[p] = lo;
			p++;
		end
		for (int unsigned i = LEN_POS; i < p; i++)
			frame_wr[i] = 1'b1;
		wr_pos = new_end;
		csum = '0;
		for (int unsigned d = 0; d < wr_pos; d++)
			csum ^= frame_mem[d];
		store_byte(cfg_ctrl);
		store_byte(cfg_fend);
		store_byte(csum);
		store_byte(TRAILER_PAD);
		saved_len = flen;
		done_q = 1'b1;
	endfunction

	// Advance the frame image by one accepted item and return the result it causes
	function automatic out_t predict_frame_step(input in_t item);
		out_t res;
		logic [7:0] rd_val;
		bit bad_code;
		int unsigned n;
		rd_val = '0;
		bad_code = 1'b0;
		case (op_t'(item.opcode))
			OP_BEGIN: begin
				frame_mem[0] = cfg_ctrl;
				frame_mem[1] = cfg_fstart;
				frame_wr[0] = 1'b1;
				frame_wr[1] = 1'b1;
				wr_pos = FIRST_REC;
				done_q = 1'b0;
				ovf_q = 1'b0;
				saved_len = 0;
			end
			OP_ADD: begin
				if (!done_q) begin
					n = data_byte_count(item.type_code);
					if (n == 0) begin
						bad_code = 1'b1;
					end else begin
						store_byte(cfg_ctrl);
						store_stuffed(cfg_pstart);
						store_stuffed(item.type_code);
						store_stuffed(item.param_index[15:8]);
						store_stuffed(item.param_index[7:0]);
						for (int i = int'(n) - 1; i >= 0; i--)
							store_stuffed(item.param_data[8*i +: 8]);
					end
				end
			end
			OP_END: begin
				if (!done_q)
					close_frame();
			end
			default: begin
				rd_val = frame_mem[item.read_address];
			end
		endcase
		res.read_byte = rd_val;
		res.total_length = done_q ? LEN_W'(wr_pos) : '0;
		res.length_field = done_q ? LEN_W'(saved_len) : '0;
		res.status = bad_code ? ST_BAD_TYPE : (ovf_q ? ST_OVERFLOW : ST_OK);
		return res;
	endfunction

	function automatic in_t make_item(input op_t op, input logic [7:0] code,
			input logic [15:0] idx, input logic [63:0] data, input logic [9:0] addr);
		in_t item;
		item.opcode = op;
		item.type_code = code;
		item.param_index = idx;
		item.param_data = data;
		item.read_address = addr;
		return item;
	endfunction

	function automatic logic [7:0] byte_other_than_control();
		logic [7:0] b;
		do b = 8'($urandom); while (b == cfg_ctrl);
		return b;
	endfunction

	// Address below limit that already holds a known byte, else zero
	function automatic logic [9:0] pick_written_addr(input int unsigned limit);
		logic [9:0] a;
		repeat (20) begin
			a = 10'($urandom_range(0, limit - 1));
			if (frame_wr[a])
				return a;
		end
		return '0;
	endfunction

	// Add with random content; dense puts the control char in about half the data bytes
	function automatic in_t random_add_item(input bit dense);
		logic [7:0] code;
		logic [15:0] idx;
		logic [63:0] data;
		code = SUPPORTED_CODES[$urandom_range(0, 9)];
		if (!dense && $urandom_range(0, 7) == 0)
			code = 8'($urandom);
		idx = 16'($urandom);
		data = {$urandom, $urandom};
		for (int j = 0; j < 8; j++) begin
			if (dense ? $urandom_range(0, 1) == 0 : $urandom_range(0, 15) == 0)
				data[8*j +: 8] = cfg_ctrl;
		end
		if ($urandom_range(0, 5) == 0)
			idx[15:8] = cfg_ctrl;
		return make_item(OP_ADD, code, idx, data, 10'($urandom));
	endfunction

	function automatic in_t random_noise_item();
		in_t item;
		item = make_item(op_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
			{$urandom, $urandom}, 10'($urandom));
		if (!frame_wr[item.read_address])
			item.read_address = '0;
		return item;
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		$display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h", $time, results_seen,
			field, got, want);
		mismatch_count++;
	endtask

	// One input transfer; the expected result is worked out when it is accepted
	task automatic send_item(input in_t item);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_frame_step(item));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_register(input cfg_reg_t which, input logic [7:0] value);
		cfg_index <= which;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (which)
			REG_CONTROL: cfg_ctrl = value;
			REG_FRAME_START: cfg_fstart = value;
			REG_FRAME_END: cfg_fend = value;
			default: cfg_pstart = value;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering items until every result is back, then let the block settle
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic read_frame_sample(input int unsigned count);
		repeat (count)
			send_item(make_item(OP_READ, 8'($urandom), 16'($urandom), {$urandom, $urandom},
				pick_written_addr(wr_pos)));
	endtask

	// Append records of chosen stuffed size until the frame is exactly target bytes long
	task automatic fill_to(input int unsigned target);
		int unsigned room, span, n, esc, rot;
		logic [7:0] fields [10];
		logic [7:0] code;
		logic [63:0] data;
		while (!done_q && wr_pos + 6 <= target) begin
			room = target - wr_pos;
			if (room <= 23)
				span = room;
			else if (room <= 28)
				span = room - 6;
			else
				span = $urandom_range(13, 23);
			n = span >= 13 ? 8 : (span >= 9 ? 4 : (span >= 7 ? 2 : 1));
			esc = span - 5 - n;
			rot = $urandom_range(0, n + 1);
			for (int j = 0; j < n + 2; j++)
				fields[j] = ((j + rot) % (n + 2) < esc) ? cfg_ctrl : byte_other_than_control();
			do code = SUPPORTED_CODES[$urandom_range(0, 9)]; while (data_byte_count(code) != n);
			data = {$urandom, $urandom};
			for (int j = 0; j < n; j++)
				data[8*j +: 8] = fields[2 + j];
			send_item(make_item(OP_ADD, code, {fields[0], fields[1]}, data, 10'($urandom)));
		end
	endtask

	// Every type code, field extremes, stuffing, bad codes, reads, late add and end
	task automatic test_record_encoding();
		write_register(REG_CONTROL, 8'h7E);
		write_register(REG_FRAME_START, 8'h00);
		write_register(REG_FRAME_END, 8'hFF);
		write_register(REG_PARAM_START, 8'h7E);
		send_item(make_item(OP_BEGIN, 8'h00, 16'h0000, 64'h0, 10'h000));
		send_item(make_item(OP_ADD, TYPE_U8, 16'h0000, 64'h0, 10'h000));
		send_item(make_item(OP_ADD, TYPE_S8, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF));
		send_item(make_item(OP_ADD, TYPE_U16, 16'h7E7E, 64'h7E7E, 10'h000));
		send_item(make_item(OP_ADD, TYPE_S16, 16'h1234, {$urandom, $urandom}, 10'h000));
		send_item(make_item(OP_ADD, TYPE_U32, 16'h8000, 64'h7E00_7E00, 10'h000));
		send_item(make_item(OP_ADD, TYPE_S32, 16'h0001, 64'h8000_0000, 10'h000));
		send_item(make_item(OP_ADD, TYPE_F32, 16'h00FF, 64'h3F80_0000, 10'h000));
		send_item(make_item(OP_ADD, TYPE_U64, 16'hFF00, 64'h7E7E_7E7E_7E7E_7E7E, 10'h000));
		send_item(make_item(OP_ADD, TYPE_S64, 16'h5A5A, 64'h8000_0000_0000_0001, 10'h000));
		send_item(make_item(OP_ADD, TYPE_F64, 16'hA5A5, 64'h3FF0_0000_0000_0000, 10'h000));
		send_item(make_item(OP_ADD, 8'h00, 16'h1111, 64'h1, 10'h000));
		send_item(make_item(OP_ADD, 8'hFF, 16'h2222, 64'h2, 10'h000));
		send_item(make_item(OP_ADD, 8'h13, 16'h3333, 64'h3, 10'h000));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'd0));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'd1));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'd4));
		send_item(make_item(OP_END, 8'h00, 16'h0000, 64'h0, 10'h000));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'd2));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'd3));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(wr_pos - 2)));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(wr_pos - 1)));
		// Add and end after the frame is closed change nothing
		send_item(make_item(OP_ADD, TYPE_U8, 16'hBEEF, 64'h7E, 10'h000));
		send_item(make_item(OP_END, 8'h00, 16'h0000, 64'h0, 10'h000));
		read_frame_sample(1);
	endtask

	// Length bytes equal to the control char: high, low, both, and an empty frame
	task automatic test_length_escapes();
		logic [7:0] ctrl;
		int unsigned target;
		for (int c = 0; c < 4; c++) begin
			case (c)
				0: begin
					ctrl = 8'h00;
					target = $urandom_range(40, 200);
				end
				1: begin
					ctrl = 8'h04;
					target = FIRST_REC;
				end
				2: begin
					ctrl = 8'h00;
					target = 256;
				end
				default: begin
					ctrl = 8'h01;
					target = 257;
				end
			endcase
			wait_for_results();
			write_register(REG_CONTROL, ctrl);
			write_register(REG_PARAM_START, 8'hC3);
			write_register(REG_FRAME_START, 8'($urandom));
			write_register(REG_FRAME_END, 8'($urandom));
			send_item(make_item(OP_BEGIN, 8'($urandom), 16'($urandom), {$urandom, $urandom},
				10'($urandom)));
			fill_to(target);
			send_item(make_item(OP_END, 8'($urandom), 16'($urandom), {$urandom, $urandom},
				10'($urandom)));
			for (int a = LEN_POS; a < LEN_POS + 4; a++)
				send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(a)));
			send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(wr_pos - 2)));
			read_frame_sample(3);
		end
	endtask

	// Fill past the end of memory, then close a full frame whose length needs escaping
	task automatic test_overflow();
		wait_for_results();
		write_register(REG_CONTROL, 8'hFF);
		write_register(REG_FRAME_START, 8'hFF);
		write_register(REG_FRAME_END, 8'h00);
		write_register(REG_PARAM_START, 8'hFF);
		send_item(make_item(OP_BEGIN, 8'hFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF));
		while (!ovf_q)
			send_item(random_add_item(1'b1));
		send_item(random_add_item(1'b1));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(DEPTH - 1)));
		send_item(make_item(OP_END, 8'h00, 16'h0000, 64'h0, 10'h000));
		read_frame_sample(2);

		// Exactly full, high length byte equals the control char: the shift drops the tail
		wait_for_results();
		write_register(REG_CONTROL, 8'h04);
		write_register(REG_PARAM_START, 8'h5A);
		send_item(make_item(OP_BEGIN, 8'h00, 16'h0000, 64'h0, 10'h000));
		fill_to(DEPTH);
		send_item(make_item(OP_END, 8'h00, 16'h0000, 64'h0, 10'h000));
		for (int a = LEN_POS; a < LEN_POS + 3; a++)
			send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(a)));
		send_item(make_item(OP_READ, 8'h00, 16'h0000, 64'h0, 10'(DEPTH - 1)));
		send_item(make_item(OP_ADD, TYPE_U8, 16'h0000, 64'h0, 10'h000));
	endtask

	// Receiver holds off for a long stretch while items keep coming back to back
	task automatic test_backpressure();
		wait_for_results();
		sink_hold_cycles = 300;
		steady = 1'b1;
		send_item(make_item(OP_BEGIN, 8'($urandom), 16'($urandom), {$urandom, $urandom},
			10'($urandom)));
		repeat (8)
			send_item(random_add_item(1'b0));
		send_item(make_item(OP_END, 8'h00, 16'h0000, 64'h0, 10'h000));
		read_frame_sample(2);
		steady = 1'b0;
		wait_for_results();
	endtask

	// Mostly well-formed frames with random content, with noise around them
	task automatic test_random_frames();
		int unsigned first_item, frame_no;
		logic [7:0] value;
		first_item = items_sent;
		frame_no = 0;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			if (frame_no % 3 == 0) begin
				wait_for_results();
				for (int r = 0; r < 4; r++) begin
					case ($urandom_range(0, 7))
						0: value = 8'h00;
						1: value = 8'hFF;
						2: value = 8'($urandom_range(0, 4));
						default: value = 8'($urandom);
					endcase
					write_register(cfg_reg_t'(r), value);
				end
			end
			steady = (frame_no % 5 == 2);
			if ($urandom_range(0, 3) == 0)
				send_item(random_noise_item());
			send_item(make_item(OP_BEGIN, 8'($urandom), 16'($urandom), {$urandom, $urandom},
				10'($urandom)));
			if ($urandom_range(0, 11) == 0) begin
				fill_to($urandom_range(200, DEPTH));
			end else begin
				repeat ($urandom_range(0, 10)) begin
					send_item(random_add_item($urandom_range(0, 4) == 0));
					if ($urandom_range(0, 3) == 0)
						read_frame_sample(1);
				end
			end
			send_item(make_item(OP_END, 8'($urandom), 16'($urandom), {$urandom, $urandom},
				10'($urandom)));
			read_frame_sample($urandom_range(1, 3));
			if ($urandom_range(0, 2) == 0)
				send_item(random_noise_item());
			frame_no++;
		end
		steady = 1'b0;
	endtask

	// Receiver: random stall before each transfer, or a long hold when a test asks
	initial begin : result_sink
		int unsigned pause;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			pause = steady ? 0 : $urandom_range(0, 10);
			if (sink_hold_cycles != 0) begin
				pause = sink_hold_cycles;
				sink_hold_cycles = 0;
			end
			if (pause != 0) begin
				out_ready <= 1'b0;
				repeat (pause) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Compare each result transfer with the oldest expected result
	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", out_data, 0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.read_byte !== want.read_byte)
					report_mismatch("read_byte", out_data.read_byte, want.read_byte);
				if (out_data.total_length !== want.total_length)
					report_mismatch("total_length", out_data.total_length, want.total_length);
				if (out_data.length_field !== want.length_field)
					report_mismatch("length_field", out_data.length_field, want.length_field);
				if (out_data.status !== want.status)
					report_mismatch("status", out_data.status, want.status);
			end
		end
	end

	// Watchdog: too long without any transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_record_encoding();
		test_length_escapes();
		test_overflow();
		test_backpressure();
		test_random_frames();
		wait_for_results();
		repeat (40) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results outstanding", expected_results.size(), 0);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
